### hw/rtl/nlc_pkg.sv
// Shared types and codes for the numeric literal classifier.
package nlc_pkg;

  // Character classes produced by the front end, one per input word.
  typedef enum logic [4:0] {
    CC_ZERO,     // '0'
    CC_DIGIT,    // '1'..'9'
    CC_DOT,      // '.'
    CC_UNDER,    // '_'
    CC_SIGN,     // '+' or '-'
    CC_XDIG,     // a c d A C D
    CC_LET_B,    // b B
    CC_LET_E,    // e E
    CC_LET_F,    // f F
    CC_LET_X,    // x X
    CC_LET_P,    // p P
    CC_LET_U,    // u U
    CC_LET_I,    // i
    CC_LET_L,    // L
    CC_LETTER,   // any other ASCII letter
    CC_FOREIGN,  // above 0x7f, not a line separator
    CC_OTHER     // end of input, white space, punctuation, line separators
  } char_class_t;

  typedef enum logic [2:0] {
    PH_START,
    PH_LEAD_DOT,
    PH_AFTER_ZERO,
    PH_MAIN,
    PH_EXP_SIGN,
    PH_DOT_PENDING,
    PH_SUFFIX
  } phase_t;

  typedef enum logic [1:0] {
    SK_NONE,
    SK_INT,
    SK_FLOAT
  } suffix_kind_t;

  typedef struct packed {
    logic l;
    logic i;
    logic f;
    logic u;
  } suffix_seen_t;

  localparam logic [1:0] ST_PENDING = 2'd0;
  localparam logic [1:0] ST_INT     = 2'd1;
  localparam logic [1:0] ST_FLOAT   = 2'd2;
  localparam logic [1:0] ST_REJECT  = 2'd3;

  localparam int unsigned CHAR_W = 21;
  localparam int unsigned LEN_W  = 8;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_INT_ALLOWED   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOAT_ALLOWED = 1'd1;

  typedef struct packed {
    logic [1:0]       status;
    logic [LEN_W-1:0] token_length;
  } result_t;

endpackage

### hw/rtl/nlc_fifo.sv
// Small register FIFO used as the class queue and the result queue.
module nlc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### hw/rtl/nlc_front.sv
// Front end: takes code points and reduces each to a character class.
module nlc_front (
  input  logic                       in_push,
  input  logic [nlc_pkg::CHAR_W-1:0] in_char_code,
  input  logic                       q_full,
  output logic                       q_push,
  output nlc_pkg::char_class_t       q_class
);

  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_NINE  = 7'h39;
  localparam logic [6:0] CH_DOT   = 7'h2e;
  localparam logic [6:0] CH_UNDER = 7'h5f;
  localparam logic [6:0] CH_PLUS  = 7'h2b;
  localparam logic [6:0] CH_MINUS = 7'h2d;
  localparam logic [6:0] CH_LOW_I = 7'h69;
  localparam logic [6:0] CH_UP_L  = 7'h4c;
  localparam logic [nlc_pkg::CHAR_W-1:0] ASCII_MAX = 21'h7f;
  localparam logic [nlc_pkg::CHAR_W-1:0] LINE_SEP  = 21'h2028;
  localparam logic [nlc_pkg::CHAR_W-1:0] PARA_SEP  = 21'h2029;

  logic       ascii;
  logic [6:0] ch;
  logic [6:0] lc;      // folded to lower case, meaningful for letters only
  logic       letter;

  assign q_push = in_push & ~q_full;
  assign ascii  = (in_char_code <= ASCII_MAX);
  assign ch     = in_char_code[6:0];
  assign lc     = ch | 7'h20;
  assign letter = ascii && ((ch >= 7'h41 && ch <= 7'h5a) || (ch >= 7'h61 && ch <= 7'h7a));

  always_comb begin
    q_class = nlc_pkg::CC_OTHER;
    priority if (!ascii) begin
      if (in_char_code != LINE_SEP && in_char_code != PARA_SEP) begin
        q_class = nlc_pkg::CC_FOREIGN;
      end
    end else if (ch == CH_ZERO) begin
      q_class = nlc_pkg::CC_ZERO;
    end else if (ch > CH_ZERO && ch <= CH_NINE) begin
      q_class = nlc_pkg::CC_DIGIT;
    end else if (ch == CH_DOT) begin
      q_class = nlc_pkg::CC_DOT;
    end else if (ch == CH_UNDER) begin
      q_class = nlc_pkg::CC_UNDER;
    end else if (ch == CH_PLUS || ch == CH_MINUS) begin
      q_class = nlc_pkg::CC_SIGN;
    end else if (ch == CH_LOW_I) begin
      q_class = nlc_pkg::CC_LET_I;
    end else if (ch == CH_UP_L) begin
      q_class = nlc_pkg::CC_LET_L;
    end else if (letter) begin
      unique case (lc)
        7'h62:   q_class = nlc_pkg::CC_LET_B;
        7'h65:   q_class = nlc_pkg::CC_LET_E;
        7'h66:   q_class = nlc_pkg::CC_LET_F;
        7'h78:   q_class = nlc_pkg::CC_LET_X;
        7'h70:   q_class = nlc_pkg::CC_LET_P;
        7'h75:   q_class = nlc_pkg::CC_LET_U;
        7'h61,
        7'h63,
        7'h64:   q_class = nlc_pkg::CC_XDIG;
        default: q_class = nlc_pkg::CC_LETTER;
      endcase
    end else begin
      q_class = nlc_pkg::CC_OTHER;
    end
  end

endmodule

### hw/rtl/nlc_back.sv
// Back end: token state machine, one class per unstalled cycle.
module nlc_back #(
  parameter int unsigned MAX_TOKEN_LEN = 255
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_valid,
  input  logic [nlc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                          cfg_data,
  // class queue
  input  logic                          q_empty,
  input  nlc_pkg::char_class_t          q_class,
  output logic                          q_pop,
  // result queue
  input  logic                          r_full,
  output logic                          r_push,
  output nlc_pkg::result_t              r_data
);

  localparam int unsigned CNT_W = $clog2(MAX_TOKEN_LEN + 1);

  logic                  int_allowed_r, float_allowed_r;
  nlc_pkg::phase_t       phase_r, phase_nxt;
  logic                  rx_hex_r, rx_hex_nxt, rx_bin_r, rx_bin_nxt;
  logic                  pg_dig_r, pg_dig_nxt, pg_dot_r, pg_dot_nxt, pg_exp_r, pg_exp_nxt;
  nlc_pkg::suffix_seen_t sf_r, sf_nxt;
  nlc_pkg::suffix_kind_t sk_r, sk_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  step;
  logic [1:0]            dec_status;
  logic [CNT_W-1:0]      dec_len;

  assign step = ~q_empty & ~r_full;

  function automatic logic [CNT_W-1:0] adv(input logic [CNT_W-1:0] c);
    adv = (c < CNT_W'(MAX_TOKEN_LEN)) ? c + 1'b1 : c;
  endfunction

  // next state and decision
  always_comb begin
    nlc_pkg::phase_t       ph;
    nlc_pkg::suffix_seen_t sf;
    nlc_pkg::suffix_kind_t sk, kind;
    logic [CNT_W-1:0]      cnt;
    logic hex, bin, dig, dot, exp, done, en, is_dig, is_xl, is_alnum, isf, isp;
    ph  = phase_r;
    hex = rx_hex_r;
    bin = rx_bin_r;
    dig = pg_dig_r;
    dot = pg_dot_r;
    exp = pg_exp_r;
    sf  = sf_r;
    sk  = sk_r;
    cnt = cnt_r;
    kind = nlc_pkg::SK_NONE;
    isf  = 1'b0;
    isp  = 1'b0;
    done = 1'b0;
    dec_status = nlc_pkg::ST_PENDING;
    dec_len    = '0;
    en       = int_allowed_r | float_allowed_r;
    is_dig   = (q_class == nlc_pkg::CC_ZERO) || (q_class == nlc_pkg::CC_DIGIT);
    is_xl    = (q_class == nlc_pkg::CC_XDIG) || (q_class == nlc_pkg::CC_LET_B) ||
               (q_class == nlc_pkg::CC_LET_E) || (q_class == nlc_pkg::CC_LET_F);
    is_alnum = is_dig || (q_class >= nlc_pkg::CC_XDIG && q_class <= nlc_pkg::CC_LETTER);

    // lead-in phases, settle or hand over to the main phase
    unique case (ph)
      nlc_pkg::PH_START: begin
        if (q_class == nlc_pkg::CC_DOT) begin
          cnt = adv(cnt); ph = nlc_pkg::PH_LEAD_DOT; done = 1'b1;
        end else if (q_class == nlc_pkg::CC_ZERO) begin
          cnt = adv(cnt); ph = nlc_pkg::PH_AFTER_ZERO; done = 1'b1;
        end else if (q_class == nlc_pkg::CC_DIGIT && en) begin
          ph = nlc_pkg::PH_MAIN;
        end else begin
          done = 1'b1; dec_status = nlc_pkg::ST_REJECT;
        end
      end
      nlc_pkg::PH_LEAD_DOT: begin
        if (!is_dig || !en) begin
          done = 1'b1; dec_status = nlc_pkg::ST_REJECT;
        end else begin
          dot = 1'b1; ph = nlc_pkg::PH_MAIN;
        end
      end
      nlc_pkg::PH_AFTER_ZERO: begin
        if (q_class == nlc_pkg::CC_LET_B || q_class == nlc_pkg::CC_LET_X) begin
          bin  = (q_class == nlc_pkg::CC_LET_B);
          hex  = (q_class == nlc_pkg::CC_LET_X);
          cnt  = adv(cnt);
          done = 1'b1;
          ph   = nlc_pkg::PH_MAIN;
          if (!en) dec_status = nlc_pkg::ST_REJECT;
        end else if (!en) begin
          done = 1'b1; dec_status = nlc_pkg::ST_REJECT;
        end else begin
          dig = 1'b1; ph = nlc_pkg::PH_MAIN;
        end
      end
      nlc_pkg::PH_EXP_SIGN: begin
        ph = nlc_pkg::PH_MAIN;
        if (q_class == nlc_pkg::CC_SIGN) begin
          cnt = adv(cnt); done = 1'b1;
        end
      end
      nlc_pkg::PH_DOT_PENDING: begin
        if (is_dig || (hex && is_xl)) begin
          dot = 1'b1; ph = nlc_pkg::PH_MAIN;
        end else if (is_alnum || q_class == nlc_pkg::CC_UNDER ||
                     q_class == nlc_pkg::CC_DOT || q_class == nlc_pkg::CC_FOREIGN) begin
          // dot starts a property: integer without the dot
          done = 1'b1;
          if (int_allowed_r) begin
            dec_status = nlc_pkg::ST_INT; dec_len = cnt - 1'b1;
          end else begin
            dec_status = nlc_pkg::ST_REJECT;
          end
        end else begin
          done = 1'b1;
          if (float_allowed_r) begin
            dec_status = nlc_pkg::ST_FLOAT; dec_len = cnt;
          end else begin
            dec_status = nlc_pkg::ST_REJECT;
          end
        end
      end
      nlc_pkg::PH_MAIN, nlc_pkg::PH_SUFFIX: begin
      end
      default: begin
        done = 1'b1; dec_status = nlc_pkg::ST_REJECT;
      end
    endcase

    // main body: digits, underscores, dot, exponent
    if (!done && ph == nlc_pkg::PH_MAIN) begin
      isp = (q_class == nlc_pkg::CC_LET_P);
      if (is_dig || (hex && !exp && is_xl)) begin
        cnt = adv(cnt); dig = 1'b1; done = 1'b1;
      end else if (q_class == nlc_pkg::CC_DOT && dig && !dot && !exp && !bin) begin
        cnt = adv(cnt); ph = nlc_pkg::PH_DOT_PENDING; done = 1'b1;
      end else if (q_class == nlc_pkg::CC_UNDER) begin
        cnt = adv(cnt); done = 1'b1;
      end else if (q_class == nlc_pkg::CC_LET_E || isp) begin
        done = 1'b1;
        if (exp || bin || (hex && !isp) || (!hex && isp)) begin
          dec_status = nlc_pkg::ST_REJECT;
        end else begin
          cnt = adv(cnt); dig = 1'b0; exp = 1'b1; ph = nlc_pkg::PH_EXP_SIGN;
        end
      end else if (!dig) begin
        done = 1'b1; dec_status = nlc_pkg::ST_REJECT;
      end else begin
        ph = nlc_pkg::PH_SUFFIX;
      end
    end

    // suffixes and the end of the token
    if (!done && ph == nlc_pkg::PH_SUFFIX) begin
      done = 1'b1;
      isf  = dot | exp;
      if (q_class == nlc_pkg::CC_LET_U) begin
        if (sf.u || sf.i || sf.f || isf) begin
          dec_status = nlc_pkg::ST_REJECT;
        end else begin
          sf.u = 1'b1; sk = nlc_pkg::SK_INT; cnt = adv(cnt);
        end
      end else if (q_class == nlc_pkg::CC_LET_F) begin
        if (sf.u || sf.f || sf.i) begin
          dec_status = nlc_pkg::ST_REJECT;
        end else begin
          sf.f = 1'b1; sk = nlc_pkg::SK_FLOAT; cnt = adv(cnt);
        end
      end else if (q_class == nlc_pkg::CC_LET_I) begin
        if (sf.i || sf.u) begin
          dec_status = nlc_pkg::ST_REJECT;
        end else begin
          sf.i = 1'b1; sk = nlc_pkg::SK_FLOAT; cnt = adv(cnt);
        end
      end else if (q_class == nlc_pkg::CC_LET_L) begin
        if (sf.l || sf.f || sf.i) begin
          dec_status = nlc_pkg::ST_REJECT;
        end else begin
          sf.l = 1'b1; cnt = adv(cnt);
        end
      end else if (is_alnum || q_class == nlc_pkg::CC_FOREIGN) begin
        dec_status = nlc_pkg::ST_REJECT;
      end else begin
        kind = isf ? nlc_pkg::SK_FLOAT : sk;
        if (int_allowed_r && kind != nlc_pkg::SK_FLOAT) begin
          dec_status = nlc_pkg::ST_INT; dec_len = cnt;
        end else if (float_allowed_r && kind != nlc_pkg::SK_INT) begin
          dec_status = nlc_pkg::ST_FLOAT; dec_len = cnt;
        end else begin
          dec_status = nlc_pkg::ST_REJECT;
        end
      end
    end

    phase_nxt  = phase_r;
    rx_hex_nxt = rx_hex_r;
    rx_bin_nxt = rx_bin_r;
    pg_dig_nxt = pg_dig_r;
    pg_dot_nxt = pg_dot_r;
    pg_exp_nxt = pg_exp_r;
    sf_nxt     = sf_r;
    sk_nxt     = sk_r;
    cnt_nxt    = cnt_r;
    if (step) begin
      if (dec_status != nlc_pkg::ST_PENDING) begin
        phase_nxt  = nlc_pkg::PH_START;
        rx_hex_nxt = 1'b0;
        rx_bin_nxt = 1'b0;
        pg_dig_nxt = 1'b0;
        pg_dot_nxt = 1'b0;
        pg_exp_nxt = 1'b0;
        sf_nxt     = '0;
        sk_nxt     = nlc_pkg::SK_NONE;
        cnt_nxt    = '0;
      end else begin
        phase_nxt  = ph;
        rx_hex_nxt = hex;
        rx_bin_nxt = bin;
        pg_dig_nxt = dig;
        pg_dot_nxt = dot;
        pg_exp_nxt = exp;
        sf_nxt     = sf;
        sk_nxt     = sk;
        cnt_nxt    = cnt;
      end
    end
  end

  // outputs
  always_comb begin
    logic [15:0] len_ext;
    len_ext             = 16'(dec_len);
    q_pop               = step;
    r_push              = step;
    r_data.status       = dec_status;
    r_data.token_length = (len_ext > 16'd255) ? 8'hff : len_ext[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_allowed_r   <= 1'b1;
      float_allowed_r <= 1'b1;
      phase_r         <= nlc_pkg::PH_START;
      rx_hex_r        <= 1'b0;
      rx_bin_r        <= 1'b0;
      pg_dig_r        <= 1'b0;
      pg_dot_r        <= 1'b0;
      pg_exp_r        <= 1'b0;
      sf_r            <= '0;
      sk_r            <= nlc_pkg::SK_NONE;
      cnt_r           <= '0;
    end else begin
      if (cfg_valid && cfg_index == nlc_pkg::CFG_INT_ALLOWED) begin
        int_allowed_r <= cfg_data;
      end
      if (cfg_valid && cfg_index == nlc_pkg::CFG_FLOAT_ALLOWED) begin
        float_allowed_r <= cfg_data;
      end
      phase_r  <= phase_nxt;
      rx_hex_r <= rx_hex_nxt;
      rx_bin_r <= rx_bin_nxt;
      pg_dig_r <= pg_dig_nxt;
      pg_dot_r <= pg_dot_nxt;
      pg_exp_r <= pg_exp_nxt;
      sf_r     <= sf_nxt;
      sk_r     <= sk_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_settled_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && dec_status != nlc_pkg::ST_PENDING |=> cnt_r == '0 && phase_r == nlc_pkg::PH_START)
    else $error("token state not cleared after a settled word");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_TOKEN_LEN))
    else $error("consumed count beyond saturation");

  a_dot_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == nlc_pkg::PH_DOT_PENDING |-> pg_dig_r && !pg_dot_r && !pg_exp_r)
    else $error("pending dot without digits");

  a_suffix_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == nlc_pkg::PH_SUFFIX |-> pg_dig_r)
    else $error("suffix phase without digits");

  a_radix_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(rx_hex_r && rx_bin_r))
    else $error("hex and binary both set");

  a_pending_no_len: assert property (@(posedge clk) disable iff (!rst_n)
    r_push && (r_data.status == nlc_pkg::ST_PENDING || r_data.status == nlc_pkg::ST_REJECT)
    |-> r_data.token_length == '0)
    else $error("length on a pending or rejected word");

endmodule

### hw/rtl/numeric_literal_classifier.sv
// Numeric literal classifier: throughput of one code point per clock while the queues have
// room. A word pushed at the input is classified by the front end and queued; the back-end
// state machine takes one queued class per cycle unless the queues stall it and writes exactly
// one result (pending, integer, float or rejected, plus the token length) into the output
// queue, where it can be popped once registered. The back end's state update sets the rate;
// the two queues let either side stall without stopping the other. Configuration writes are
// always ready and must only be issued while no character is in flight.
module numeric_literal_classifier #(
  parameter int unsigned MAX_TOKEN_LEN = 255,  // saturation of the consumed count, 16..65535
  parameter int unsigned QUEUE_DEPTH   = 2     // depth of both queues, at least 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // character input
  input  logic                          in_push,
  input  logic [nlc_pkg::CHAR_W-1:0]    in_char_code,
  output logic                          in_full,
  // results
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [1:0]                    out_status,
  output logic [nlc_pkg::LEN_W-1:0]     out_token_length,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [nlc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                          cfg_data
);

  localparam int unsigned CLS_W = $bits(nlc_pkg::char_class_t);
  localparam int unsigned RES_W = $bits(nlc_pkg::result_t);

  logic                 q_push, q_full, q_empty, q_pop;
  nlc_pkg::char_class_t q_wr_class, q_rd_class;
  logic [CLS_W-1:0]     q_rd_raw;
  logic                 r_push, r_full;
  nlc_pkg::result_t     r_wr, r_rd;
  logic [RES_W-1:0]     r_rd_raw;

  assign cfg_ready = 1'b1;

  // front end: classify each incoming code point
  nlc_front u_front (
    .in_push      (in_push),
    .in_char_code (in_char_code),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_class      (q_wr_class)
  );

  assign in_full = q_full;

  // class queue between front and back
  nlc_fifo #(
    .WIDTH (CLS_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_class_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_class),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_raw),
    .empty   (q_empty)
  );

  assign q_rd_class = nlc_pkg::char_class_t'(q_rd_raw);

  // back end: token state machine and configuration registers
  nlc_back #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_empty   (q_empty),
    .q_class   (q_rd_class),
    .q_pop     (q_pop),
    .r_full    (r_full),
    .r_push    (r_push),
    .r_data    (r_wr)
  );

  // result queue towards the consumer
  nlc_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (r_push),
    .wr_data (r_wr),
    .full    (r_full),
    .pop     (out_pop),
    .rd_data (r_rd_raw),
    .empty   (out_empty)
  );

  assign r_rd             = nlc_pkg::result_t'(r_rd_raw);
  assign out_status       = r_rd.status;
  assign out_token_length = r_rd.token_length;

endmodule

### dv/testbench.sv
// Self-checking testbench for the numeric literal classifier: directed table, then random tokens.
`timescale 1ns / 1ps

module testbench;

  // Run shape
  localparam int unsigned TOKEN_LEN_CAP      = 255;   // consumed-count saturation
  localparam int unsigned RESULT_HOLD_CYCLES = 200;   // receiver hold-off to back the block up
  localparam int unsigned QUIET_LIMIT        = 1000;  // cycles with no handshake at all
  localparam int unsigned IDLE_PERCENT       = 38;

  // Character codes with a meaning of their own
  localparam logic [nlc_pkg::CHAR_W-1:0] ASCII_MAX = 21'h7F;
  localparam logic [nlc_pkg::CHAR_W-1:0] LINE_SEP  = 21'h2028;
  localparam logic [nlc_pkg::CHAR_W-1:0] PARA_SEP  = 21'h2029;
  localparam logic [nlc_pkg::CHAR_W-1:0] CODE_TOP  = 21'h1FFFFF;

  // Radix flags and progress flag positions of the token tracker
  localparam logic [1:0] RADIX_HEX = 2'b01;
  localparam logic [1:0] RADIX_BIN = 2'b10;
  localparam int DIGIT_SEEN = 0;
  localparam int DOT_SEEN   = 1;
  localparam int IN_EXP     = 2;

  // One directed row: the word to push and, where it is obvious, the verdict typed in.
  typedef struct packed {
    logic [nlc_pkg::CHAR_W-1:0] code;
    logic                       fixed;
    nlc_pkg::result_t           want;
  } stim_row_t;

  // Directed walk through prefixes, dot handling, exponents, suffixes and bad first
  // characters. Rows with fixed clear are checked against the tracker below.
  localparam stim_row_t DIRECTED [26] = '{
    '{"0",      1'b1, '{nlc_pkg::ST_PENDING, 8'd0}},  // first word after reset
    '{"x",      1'b0, '0},
    '{"F",      1'b0, '0},
    '{".",      1'b0, '0},
    '{"a",      1'b0, '0},                   // hex digit after the dot
    '{"p",      1'b0, '0},
    '{"-",      1'b0, '0},
    '{"9",      1'b0, '0},
    '{"L",      1'b0, '0},
    '{" ",      1'b0, '0},                   // settles 0xF.ap-9L as a float
    '{"1",      1'b0, '0},
    '{".",      1'b0, '0},
    '{".",      1'b1, '{nlc_pkg::ST_INT, 8'd1}},      // "1.." : integer, dot left out
    '{"0",      1'b0, '0},
    '{"b",      1'b0, '0},
    '{"1",      1'b0, '0},
    '{"u",      1'b0, '0},
    '{21'd0,    1'b0, '0},                   // end of input settles 0b1u
    '{LINE_SEP, 1'b1, '{nlc_pkg::ST_REJECT, 8'd0}},   // bad first character
    '{CODE_TOP, 1'b1, '{nlc_pkg::ST_REJECT, 8'd0}},   // top of the field, beyond Unicode
    '{"5",      1'b0, '0},
    '{".",      1'b0, '0},
    '{";",      1'b1, '{nlc_pkg::ST_FLOAT, 8'd2}},    // trailing dot kept in a float
    '{"3",      1'b0, '0},
    '{"i",      1'b0, '0},
    '{21'h10FFFF, 1'b1, '{nlc_pkg::ST_REJECT, 8'd0}}  // foreign code point after a suffix
  };

  logic                          clk;
  logic                          rst_n;
  logic                          in_push;
  logic [nlc_pkg::CHAR_W-1:0]    in_char_code;
  logic                          in_full;
  logic                          out_empty;
  logic                          out_pop;
  logic [1:0]                    out_status;
  logic [nlc_pkg::LEN_W-1:0]     out_token_length;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [nlc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic                          cfg_data;

  numeric_literal_classifier #(.MAX_TOKEN_LEN(TOKEN_LEN_CAP)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_char_code     (in_char_code),
    .in_full          (in_full),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_status       (out_status),
    .out_token_length (out_token_length),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Token tracker: our own copy of the block's state and registers.
  // --------------------------------------------------------------------------
  logic                  allow_int    = 1'b1;
  logic                  allow_float  = 1'b1;
  nlc_pkg::phase_t       lex_phase    = nlc_pkg::PH_START;
  logic [1:0]            lex_radix    = '0;
  logic [2:0]            lex_progress = '0;
  nlc_pkg::suffix_seen_t lex_suffix   = '0;
  nlc_pkg::suffix_kind_t lex_kind     = nlc_pkg::SK_NONE;
  int unsigned           lex_count    = 0;

  nlc_pkg::result_t verdicts_due [$];  // verdicts still to come out, oldest first
  int unsigned      wrong_verdicts = 0;
  int unsigned      chars_pushed;
  bit               idle_on = 1'b1;
  bit               hold_results = 1'b0;

  // ASCII only counts as digit, letter or white space
  function automatic bit is_digit(input logic [nlc_pkg::CHAR_W-1:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_hexdig(input logic [nlc_pkg::CHAR_W-1:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic bit is_alnum(input logic [nlc_pkg::CHAR_W-1:0] c);
    return is_digit(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // space, tab .. carriage return
  function automatic bit is_space(input logic [nlc_pkg::CHAR_W-1:0] c);
    return c == " " || (c >= 21'd9 && c <= 21'd13);
  endfunction

  function automatic bit is_foreign(input logic [nlc_pkg::CHAR_W-1:0] c);
    return c > ASCII_MAX && c != LINE_SEP && c != PARA_SEP;
  endfunction

  function automatic void bump();
    if (lex_count < TOKEN_LEN_CAP) lex_count++;
  endfunction

  // Any verdict other than pending drops the token state.
  function automatic nlc_pkg::result_t settle(input logic [1:0] st, input int unsigned len);
    nlc_pkg::result_t r;
    r.status       = st;
    r.token_length = (len > 255) ? 8'd255 : 8'(len);
    if (st != nlc_pkg::ST_PENDING) begin
      lex_phase    = nlc_pkg::PH_START;
      lex_radix    = '0;
      lex_progress = '0;
      lex_suffix   = '0;
      lex_kind     = nlc_pkg::SK_NONE;
      lex_count    = 0;
    end
    return r;
  endfunction

  // Body ends on this word: on to the suffixes if a digit was seen, else reject.
  function automatic bit leave_main(output nlc_pkg::result_t r);
    r = '0;
    if (!lex_progress[DIGIT_SEEN]) begin
      r = settle(nlc_pkg::ST_REJECT, 0);
      return 1'b1;
    end
    lex_phase = nlc_pkg::PH_SUFFIX;
    return 1'b0;
  endfunction

  // One word in, one verdict out. A branch that clears done looks at the same word
  // again in the new phase.
  function automatic nlc_pkg::result_t classify_char(input logic [nlc_pkg::CHAR_W-1:0] c);
    nlc_pkg::result_t      r;
    bit                    done, any_on, hex, bin, inexp, isp, isf;
    nlc_pkg::suffix_kind_t kind;
    r      = '0;
    done   = 1'b0;
    any_on = allow_int | allow_float;
    while (!done) begin
      hex   = (lex_radix & RADIX_HEX) != 0;
      bin   = (lex_radix & RADIX_BIN) != 0;
      inexp = lex_progress[IN_EXP];
      done  = 1'b1;
      unique case (lex_phase)
        nlc_pkg::PH_START: begin
          if (c == ".") begin
            bump();
            lex_phase = nlc_pkg::PH_LEAD_DOT;
            r = settle(nlc_pkg::ST_PENDING, 0);
          end else if (c == "0") begin
            bump();
            lex_phase = nlc_pkg::PH_AFTER_ZERO;
            r = settle(nlc_pkg::ST_PENDING, 0);
          end else if (is_digit(c) && any_on) begin
            lex_phase = nlc_pkg::PH_MAIN;
            done = 1'b0;
          end else begin
            r = settle(nlc_pkg::ST_REJECT, 0);
          end
        end
        nlc_pkg::PH_LEAD_DOT: begin
          if (is_digit(c) && any_on) begin
            lex_progress[DOT_SEEN] = 1'b1;
            lex_phase = nlc_pkg::PH_MAIN;
            done = 1'b0;
          end else begin
            r = settle(nlc_pkg::ST_REJECT, 0);
          end
        end
        nlc_pkg::PH_AFTER_ZERO: begin
          if (c == "b" || c == "B" || c == "x" || c == "X") begin
            lex_radix = (c == "b" || c == "B") ? RADIX_BIN : RADIX_HEX;
            bump();
            if (any_on) begin
              lex_phase = nlc_pkg::PH_MAIN;
              r = settle(nlc_pkg::ST_PENDING, 0);
            end else begin
              r = settle(nlc_pkg::ST_REJECT, 0);
            end
          end else begin
            lex_progress[DIGIT_SEEN] = 1'b1;
            if (any_on) begin
              lex_phase = nlc_pkg::PH_MAIN;
              done = 1'b0;
            end else begin
              r = settle(nlc_pkg::ST_REJECT, 0);
            end
          end
        end
        nlc_pkg::PH_EXP_SIGN: begin
          lex_phase = nlc_pkg::PH_MAIN;
          if (c == "+" || c == "-") begin
            bump();
            r = settle(nlc_pkg::ST_PENDING, 0);
          end else begin
            done = 1'b0;
          end
        end
        nlc_pkg::PH_MAIN: begin
          if (c == 0 || c > ASCII_MAX || is_space(c) || c == ";") begin
            done = leave_main(r);
          end else if ((bin && (c == "0" || c == "1")) || is_digit(c) ||
                       (hex && !inexp && is_hexdig(c))) begin
            bump();
            lex_progress[DIGIT_SEEN] = 1'b1;
            r = settle(nlc_pkg::ST_PENDING, 0);
          end else if (c == ".") begin
            if (!lex_progress[DIGIT_SEEN] || lex_progress[DOT_SEEN] || inexp || bin) begin
              done = leave_main(r);
            end else begin
              bump();
              lex_phase = nlc_pkg::PH_DOT_PENDING;
              r = settle(nlc_pkg::ST_PENDING, 0);
            end
          end else if (c == "_") begin
            bump();
            r = settle(nlc_pkg::ST_PENDING, 0);
          end else if (c == "e" || c == "E" || c == "p" || c == "P") begin
            isp = (c == "p" || c == "P");
            if (inexp || bin || (hex != isp)) begin
              r = settle(nlc_pkg::ST_REJECT, 0);
            end else begin
              bump();
              lex_progress[DIGIT_SEEN] = 1'b0;
              lex_progress[IN_EXP]     = 1'b1;
              lex_phase = nlc_pkg::PH_EXP_SIGN;
              r = settle(nlc_pkg::ST_PENDING, 0);
            end
          end else begin
            done = leave_main(r);
          end
        end
        nlc_pkg::PH_DOT_PENDING: begin
          if (is_digit(c) || (hex && is_hexdig(c))) begin
            lex_progress[DOT_SEEN] = 1'b1;
            lex_phase = nlc_pkg::PH_MAIN;
            done = 1'b0;
          end else if (is_alnum(c) || c == "_" || c == "." || is_foreign(c)) begin
            // member access or range: integer without the dot
            r = allow_int ? settle(nlc_pkg::ST_INT, lex_count - 1)
                          : settle(nlc_pkg::ST_REJECT, 0);
          end else begin
            r = allow_float ? settle(nlc_pkg::ST_FLOAT, lex_count)
                            : settle(nlc_pkg::ST_REJECT, 0);
          end
        end
        default: begin  // suffixes
          isf = lex_progress[DOT_SEEN] | lex_progress[IN_EXP];
          if (c == "u" || c == "U") begin
            if (lex_suffix.u || lex_suffix.i || lex_suffix.f || isf) begin
              r = settle(nlc_pkg::ST_REJECT, 0);
            end else begin
              lex_suffix.u = 1'b1;
              lex_kind = nlc_pkg::SK_INT;
              bump();
              r = settle(nlc_pkg::ST_PENDING, 0);
            end
          end else if (c == "f" || c == "F") begin
            if (lex_suffix.u || lex_suffix.f || lex_suffix.i) begin
              r = settle(nlc_pkg::ST_REJECT, 0);
            end else begin
              lex_suffix.f = 1'b1;
              lex_kind = nlc_pkg::SK_FLOAT;
              bump();
              r = settle(nlc_pkg::ST_PENDING, 0);
            end
          end else if (c == "i") begin
            if (lex_suffix.i || lex_suffix.u) begin
              r = settle(nlc_pkg::ST_REJECT, 0);
            end else begin
              lex_suffix.i = 1'b1;
              lex_kind = nlc_pkg::SK_FLOAT;
              bump();
              r = settle(nlc_pkg::ST_PENDING, 0);
            end
          end else if (c == "L") begin
            if (lex_suffix.l || lex_suffix.f || lex_suffix.i) begin
              r = settle(nlc_pkg::ST_REJECT, 0);
            end else begin
              lex_suffix.l = 1'b1;
              bump();
              r = settle(nlc_pkg::ST_PENDING, 0);
            end
          end else if (is_alnum(c) || is_foreign(c)) begin
            r = settle(nlc_pkg::ST_REJECT, 0);
          end else begin
            kind = isf ? nlc_pkg::SK_FLOAT : lex_kind;
            if (allow_int && kind != nlc_pkg::SK_FLOAT)
              r = settle(nlc_pkg::ST_INT, lex_count);
            else if (allow_float && kind != nlc_pkg::SK_INT)
              r = settle(nlc_pkg::ST_FLOAT, lex_count);
            else
              r = settle(nlc_pkg::ST_REJECT, 0);
          end
        end
      endcase
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Push one word, with random idle cycles ahead of it. The verdict is worked out
  // at the edge the word is taken; a typed-in verdict overrides the tracker's.
  task automatic offer_char(input logic [nlc_pkg::CHAR_W-1:0] code, input bit fixed = 1'b0,
                            input nlc_pkg::result_t want = '0);
    nlc_pkg::result_t predicted;
    while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push      <= 1'b1;
    in_char_code <= code;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predicted = classify_char(code);
    verdicts_due.push_back(fixed ? want : predicted);
    chars_pushed++;
  endtask

  function automatic logic [nlc_pkg::CHAR_W-1:0] pick_from(input string pool);
    return 21'(pool[$urandom_range(pool.len() - 1)]);
  endfunction

  // Word that closes a token: end of input, white space, line separators,
  // punctuation, letters, or anything above ASCII up to the top of the field.
  function automatic logic [nlc_pkg::CHAR_W-1:0] end_char();
    unique case ($urandom_range(9))
      0:       return 21'd0;
      1:       return ";";
      2:       return pick_from("\n\r\t");
      3:       return LINE_SEP;
      4:       return PARA_SEP;
      5:       return 21'($urandom_range(CODE_TOP, ASCII_MAX + 1));
      6:       return pick_from(",)]+*/=");
      7:       return pick_from("azAZgxq_.");
      default: return " ";
    endcase
  endfunction

  // Digits, maybe a dot part, maybe an exponent, a few suffix letters, then a closer.
  task automatic send_body(input string body, input string expo);
    repeat ($urandom_range(1, 5)) offer_char(pick_from(body));
    if ($urandom_range(99) < 35) begin
      offer_char(".");
      repeat ($urandom_range(0, 3)) offer_char(pick_from(body));
    end
    if (expo.len() != 0 && $urandom_range(99) < 35) begin
      offer_char(pick_from(expo));
      if ($urandom_range(1) == 1) offer_char(pick_from("+-"));
      repeat ($urandom_range(0, 3)) offer_char(pick_from("0123456789"));
    end
    repeat ($urandom_range(0, 2)) offer_char(pick_from("uUfFiL"));
    offer_char(end_char());
  endtask

  // Mostly well-formed literals with random content; some plain noise.
  task automatic send_token();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 15) begin
      repeat ($urandom_range(1, 4))
        offer_char(($urandom_range(3) == 0) ? 21'($urandom)
                                            : pick_from("09._xXbBeEpP+-uUfFiLgzG ;"));
    end else if (roll < 40) begin
      offer_char(pick_from("123456789"));
      send_body("0123456789_", "eE");
    end else if (roll < 50) begin
      offer_char("0");
      send_body("0123456789_", "eE");
    end else if (roll < 70) begin
      offer_char("0");
      offer_char(pick_from("xX"));
      send_body("0123456789abcdefABCDEF_", "pP");
    end else if (roll < 82) begin
      offer_char("0");
      offer_char(pick_from("bB"));
      send_body("01_", "");
    end else begin
      offer_char(".");
      send_body("0123456789", "eE");
    end
  endtask

  // Register writes only once every verdict is out; every word gives one,
  // so nothing is in flight then.
  task automatic set_allowed(input logic int_en, input logic float_en);
    in_push <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= nlc_pkg::CFG_INT_ALLOWED;
    cfg_data  <= int_en;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    allow_int = int_en;
    cfg_index <= nlc_pkg::CFG_FLOAT_ALLOWED;
    cfg_data  <= float_en;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    allow_float = float_en;
    cfg_valid <= 1'b0;
  endtask

  // One setting of the enables, then random tokens until the budget is spent.
  // long_len > 0 adds one long run of digits to exercise length saturation;
  // squeeze starts the receiver hold-off so the block fills up.
  task automatic run_phase(input logic int_en, input logic float_en, input bit steady,
                           input bit squeeze, input int unsigned budget,
                           input int unsigned long_len);
    set_allowed(int_en, float_en);
    idle_on      = !steady;
    chars_pushed = 0;
    if (squeeze) hold_results = 1'b1;
    if (long_len != 0) begin
      offer_char(pick_from("123456789"));
      repeat (long_len - 1) offer_char(pick_from("0123456789_"));
      if ($urandom_range(1) == 1) offer_char(".");
      offer_char(end_char());
    end
    while (chars_pushed < budget) send_token();
  endtask

  initial begin
    in_push      <= 1'b0;
    in_char_code <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= nlc_pkg::CFG_INT_ALLOWED;
    cfg_data     <= 1'b0;
    rst_n        <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < $size(DIRECTED); i++)
      offer_char(DIRECTED[i].code, DIRECTED[i].fixed, DIRECTED[i].want);

    // Enables: both, integer only, float only (no idling), neither, both again.
    run_phase(1'b1, 1'b1, 1'b0, 1'b1, 420, $urandom_range(256, 300));
    run_phase(1'b1, 1'b0, 1'b0, 1'b0, 260, 0);
    run_phase(1'b0, 1'b1, 1'b1, 1'b0, 260, $urandom_range(250, 255));
    run_phase(1'b0, 1'b0, 1'b0, 1'b0, 160, 0);
    run_phase(1'b1, 1'b1, 1'b0, 1'b0, 330, 0);

    in_push <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    // let any stray verdict surface before the verdict on the run
    repeat (8) @(posedge clk);
    if (wrong_verdicts == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver side
  // --------------------------------------------------------------------------

  // Pop driver: random idle cycles, and one long hold-off counted here.
  initial begin
    out_pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        hold_results = 1'b0;
        out_pop <= 1'b0;
        repeat (RESULT_HOLD_CYCLES) @(posedge clk);
      end else begin
        out_pop <= !(idle_on && $urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  // Each word popped is held against the oldest verdict due, field by field.
  always @(posedge clk) begin
    nlc_pkg::result_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: verdict with none due: status %0d, length %0d",
                 $time, out_status, out_token_length);
        wrong_verdicts++;
      end else begin
        want = verdicts_due.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want.status, out_status);
          wrong_verdicts++;
        end
        if (out_token_length !== want.token_length) begin
          $display("%0t: token_length mismatch, expected %0d, got %0d",
                   $time, want.token_length, out_token_length);
          wrong_verdicts++;
        end
      end
    end
  end

  // Watchdog: no handshake on any channel for too long means the block is stuck.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
